@@ rtl/rmq_pkg.sv @@
`default_nettype none
package rmq_pkg;

	// default field format
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	// scaled magnitudes have their largest member in [2^29, 2^30)
	localparam int SC_W = 30;
	// sum of four squares of scaled magnitudes
	localparam int SQ_W = 2 * SC_W + 2;
	// floor square root of that sum
	localparam int RT_W = SC_W + 1;
	// shift amount width for the normalizing shift
	localparam int SH_W = 6;
	// number of vector components
	localparam int NC = 4;

	// item data that rides alongside the square root pipeline
	typedef struct packed {
		logic [NC-1:0][SC_W-1:0] sc;
		logic [NC-1:0]           neg;
		logic                    deg;
	} rmq_side_t;

	// sign and degenerate flags that ride alongside the divider
	typedef struct packed {
		logic [NC-1:0] neg;
		logic          deg;
	} rmq_flag_t;

endpackage
`default_nettype wire

@@ rtl/rmq_isqrt.sv @@
`default_nettype none
module rmq_isqrt (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_vld,
	input  wire logic [rmq_pkg::SQ_W-1:0] n,
	input  wire rmq_pkg::rmq_side_t       in_side,
	output logic                          out_vld,
	output logic [rmq_pkg::RT_W-1:0]      root,
	output rmq_pkg::rmq_side_t            out_side
);
	import rmq_pkg::*;

	logic [SQ_W-1:0] rem_s  [RT_W+1];
	logic [RT_W-1:0] root_s [RT_W+1];
	rmq_side_t       side_s [RT_W+1];
	logic            vld_s  [RT_W+1];

	// stage zero is the input itself
	assign rem_s[0]  = n;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	// one result bit per stage, most significant first
	for (genvar i = 0; i < RT_W; i++) begin : g_bit
		localparam int B = RT_W - 1 - i;
		logic [63:0]     trial;
		logic            take;
		logic [SQ_W-1:0] rem_nx;
		logic [RT_W-1:0] root_nx;

		// trial subtrahend is 2*root*2^B + 2^(2B)
		always_comb begin
			trial   = (64'(root_s[i]) << (B + 1)) | (64'd1 << (2 * B));
			take    = 64'(rem_s[i]) >= trial;
			rem_nx  = take ? SQ_W'(64'(rem_s[i]) - trial) : rem_s[i];
			root_nx = take ? (root_s[i] | (RT_W'(1) << B)) : root_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= rem_nx;
				root_s[i+1] <= root_nx;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_vld  = vld_s[RT_W];
	assign root     = root_s[RT_W];
	assign out_side = side_s[RT_W];

endmodule
`default_nettype wire

@@ rtl/rmq_div.sv @@
`default_nettype none
module rmq_div #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_vld,
	input  wire logic [rmq_pkg::RT_W-1:0]          len,
	input  wire rmq_pkg::rmq_side_t                in_side,
	output logic                                   out_vld,
	output logic [rmq_pkg::NC-1:0][FRAC_BITS:0]    quo,
	output rmq_pkg::rmq_flag_t                     out_flag
);
	import rmq_pkg::*;

	localparam int QW  = FRAC_BITS + 1;
	localparam int DNW = SC_W + FRAC_BITS + 1;

	logic [NC-1:0][DNW-1:0] rem_s [QW+1];
	logic [NC-1:0][QW-1:0]  quo_s [QW+1];
	logic [RT_W-1:0]        len_s [QW+1];
	rmq_flag_t              flg_s [QW+1];
	logic                   vld_s [QW+1];

	// numerator setup: mag * ONE + floor(len / 2)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NC; c++) begin
				rem_s[0][c] <= (DNW'(in_side.sc[c]) << FRAC_BITS) + DNW'(len >> 1);
			end
			quo_s[0]     <= '0;
			len_s[0]     <= len;
			flg_s[0].neg <= in_side.neg;
			flg_s[0].deg <= in_side.deg;
		end
	end

	// restoring division, one quotient bit per stage in each lane
	for (genvar i = 0; i < QW; i++) begin : g_bit
		localparam int B = QW - 1 - i;
		logic [DNW-1:0]         dsr;
		logic [NC-1:0][DNW-1:0] rem_nx;
		logic [NC-1:0][QW-1:0]  quo_nx;

		always_comb begin
			dsr = DNW'(len_s[i]) << B;
			for (int c = 0; c < NC; c++) begin
				if (rem_s[i][c] >= dsr) begin
					rem_nx[c] = rem_s[i][c] - dsr;
					quo_nx[c] = quo_s[i][c] | (QW'(1) << B);
				end else begin
					rem_nx[c] = rem_s[i][c];
					quo_nx[c] = quo_s[i][c];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= rem_nx;
				quo_s[i+1] <= quo_nx;
				len_s[i+1] <= len_s[i];
				flg_s[i+1] <= flg_s[i];
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign quo      = quo_s[QW];
	assign out_flag = flg_s[QW];

endmodule
`default_nettype wire

@@ rtl/rotation_matrix_to_quaternion.sv @@
// Rotation matrix to unit quaternion converter.
// Input channel in_valid/in_ready carries one item: the nine matrix elements
// m_ix..m_kz, signed fixed point with FRAC_BITS fraction bits.
// Output channel out_valid/out_ready returns q_i, q_j, q_k, q_w in the same
// format plus the degenerate flag, which is set when the selected branch term
// a (one plus trace or a diagonal variant) is not positive; the identity
// quaternion is then returned. The stages are branch select, magnitude,
// leading-one position, normalizing shift, square and sum; one root bit per
// stage in the 31-stage square root; a numerator stage plus FRAC_BITS+1
// quotient stages in the four-lane divider; and one output register.
// Throughput is one item per cycle unless stalled: every stage advances together.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits, so the pipeline starts empty.
`default_nettype none
module rotation_matrix_to_quaternion #(
	parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [DATA_WIDTH-1:0] m_ix,
	input  wire logic signed [DATA_WIDTH-1:0] m_iy,
	input  wire logic signed [DATA_WIDTH-1:0] m_iz,
	input  wire logic signed [DATA_WIDTH-1:0] m_jx,
	input  wire logic signed [DATA_WIDTH-1:0] m_jy,
	input  wire logic signed [DATA_WIDTH-1:0] m_jz,
	input  wire logic signed [DATA_WIDTH-1:0] m_kx,
	input  wire logic signed [DATA_WIDTH-1:0] m_ky,
	input  wire logic signed [DATA_WIDTH-1:0] m_kz,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0]      q_i,
	output logic signed [DATA_WIDTH-1:0]      q_j,
	output logic signed [DATA_WIDTH-1:0]      q_k,
	output logic signed [DATA_WIDTH-1:0]      q_w,
	output logic                              degenerate
);
	import rmq_pkg::*;

	localparam int VW = ((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1) + 3;
	localparam int MW = VW - 1;
	localparam int QW = FRAC_BITS + 1;
	localparam logic [VW-1:0] ONE_V = VW'(64'd1 << FRAC_BITS);
	localparam logic [63:0] MAXP = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
	localparam logic [63:0] ONE_W = 64'd1 << FRAC_BITS;
	localparam logic [DATA_WIDTH-1:0] W_IDENT = DATA_WIDTH'((ONE_W > MAXP) ? MAXP : ONE_W);

	logic en;
	logic out_valid_q;

	// global advance: move unless a finished result is held
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// stage 1: branch select and direction vector
	logic signed [VW-1:0] ix, iy, iz, jx, jy, jz, kx, ky, kz, one_s, tr, a;
	logic signed [VW-1:0] v [NC];

	always_comb begin
		ix    = VW'(m_ix);
		iy    = VW'(m_iy);
		iz    = VW'(m_iz);
		jx    = VW'(m_jx);
		jy    = VW'(m_jy);
		jz    = VW'(m_jz);
		kx    = VW'(m_kx);
		ky    = VW'(m_ky);
		kz    = VW'(m_kz);
		one_s = $signed(ONE_V);
		tr    = ix + jy + kz + one_s;
		priority if (tr > 0) begin
			a    = tr;
			v[0] = jz - ky;
			v[1] = kx - iz;
			v[2] = iy - jx;
			v[3] = a;
		end else if (ix > jy && ix > kz) begin
			a    = one_s + ix - jy - kz;
			v[0] = a;
			v[1] = jx + iy;
			v[2] = iz + kx;
			v[3] = jz - ky;
		end else if (jy > kz) begin
			a    = one_s + jy - ix - kz;
			v[0] = jx + iy;
			v[1] = a;
			v[2] = ky + jz;
			v[3] = kx - iz;
		end else begin
			a    = one_s + kz - ix - jy;
			v[0] = kx + iz;
			v[1] = ky + jz;
			v[2] = a;
			v[3] = iy - jx;
		end
	end

	logic signed [VW-1:0] v_s1 [NC];
	logic                 deg_s1, vld_s1;
	logic [MW-1:0]        mag_s2 [NC];
	logic [NC-1:0]        neg_s2;
	logic                 deg_s2, vld_s2;
	logic [MW-1:0]        mag_s3 [NC];
	logic [SH_W-1:0]      p_s3;
	logic [NC-1:0]        neg_s3;
	logic                 deg_s3, vld_s3;
	logic [NC-1:0][SC_W-1:0] sc_s4;
	logic [NC-1:0]        neg_s4;
	logic                 deg_s4, vld_s4;
	logic [NC-1:0][SC_W-1:0] sc_s5;
	logic [2*SC_W-1:0]    sq_s5 [NC];
	logic [NC-1:0]        neg_s5;
	logic                 deg_s5, vld_s5;
	logic [SQ_W-1:0]      n_s6;
	rmq_side_t            side_s6;
	logic                 vld_s6;

	// position of the leading one over all magnitudes
	logic [MW-1:0]   mag_or;
	logic [SH_W-1:0] p_nx;

	always_comb begin
		mag_or = '0;
		for (int c = 0; c < NC; c++) begin
			mag_or = mag_or | mag_s2[c];
		end
		p_nx = '0;
		for (int b = 0; b < MW; b++) begin
			if (mag_or[b]) begin
				p_nx = SH_W'(b);
			end
		end
	end

	// normalizing shift so the largest magnitude sits at bit 29
	logic [63:0]             wide [NC];
	logic [NC-1:0][SC_W-1:0] sc_nx;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			if (p_s3 > SH_W'(SC_W - 1)) begin
				wide[c] = 64'(mag_s3[c]) >> (p_s3 - SH_W'(SC_W - 1));
			end else begin
				wide[c] = 64'(mag_s3[c]) << (SH_W'(SC_W - 1) - p_s3);
			end
			sc_nx[c] = wide[c][SC_W-1:0];
		end
	end

	// front pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// front pipeline data
	always_ff @(posedge clk) begin
		if (en) begin
			v_s1   <= v;
			deg_s1 <= a <= 0;
			for (int c = 0; c < NC; c++) begin
				neg_s2[c] <= v_s1[c][VW-1];
				mag_s2[c] <= v_s1[c][VW-1] ? MW'(-v_s1[c]) : MW'(v_s1[c]);
				sq_s5[c]  <= (2*SC_W)'(64'(sc_s4[c]) * 64'(sc_s4[c]));
			end
			deg_s2 <= deg_s1;
			mag_s3 <= mag_s2;
			p_s3   <= p_nx;
			neg_s3 <= neg_s2;
			deg_s3 <= deg_s2;
			sc_s4  <= sc_nx;
			neg_s4 <= neg_s3;
			deg_s4 <= deg_s3;
			sc_s5  <= sc_s4;
			neg_s5 <= neg_s4;
			deg_s5 <= deg_s4;
			n_s6   <= SQ_W'(sq_s5[0]) + SQ_W'(sq_s5[1]) + SQ_W'(sq_s5[2])
				+ SQ_W'(sq_s5[3]);
			side_s6.sc  <= sc_s5;
			side_s6.neg <= neg_s5;
			side_s6.deg <= deg_s5;
		end
	end

	// length: floor square root of the squared norm
	logic            rt_vld;
	logic [RT_W-1:0] rt_len;
	rmq_side_t       rt_side;

	rmq_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s6),
		.n        (n_s6),
		.in_side  (side_s6),
		.out_vld  (rt_vld),
		.root     (rt_len),
		.out_side (rt_side)
	);

	// components divided by the length, rounded half up
	logic                    dv_vld;
	logic [NC-1:0][QW-1:0]   dv_quo;
	rmq_flag_t               dv_flag;

	rmq_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (rt_vld),
		.len      (rt_len),
		.in_side  (rt_side),
		.out_vld  (dv_vld),
		.quo      (dv_quo),
		.out_flag (dv_flag)
	);

	// saturate, apply sign, substitute the identity when degenerate
	logic [63:0]           qm  [NC];
	logic [DATA_WIDTH-1:0] enc [NC];

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			qm[c] = (64'(dv_quo[c]) > MAXP) ? MAXP : 64'(dv_quo[c]);
			if (dv_flag.deg) begin
				enc[c] = (c == NC - 1) ? W_IDENT : '0;
			end else if (dv_flag.neg[c] && dv_quo[c] != '0) begin
				enc[c] = DATA_WIDTH'(64'd0 - qm[c]);
			end else begin
				enc[c] = DATA_WIDTH'(qm[c]);
			end
		end
	end

	// output register
	logic [DATA_WIDTH-1:0] q_i_q, q_j_q, q_k_q, q_w_q;
	logic                  deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_i_q <= enc[0];
			q_j_q <= enc[1];
			q_k_q <= enc[2];
			q_w_q <= enc[3];
			deg_q <= dv_flag.deg;
		end
	end

	assign out_valid  = out_valid_q;
	assign q_i        = $signed(q_i_q);
	assign q_j        = $signed(q_j_q);
	assign q_k        = $signed(q_k_q);
	assign q_w        = $signed(q_w_q);
	assign degenerate = deg_q;

endmodule
`default_nettype wire
